/* rtl/oltw_pkg.sv */
// Octagon lattice weave shader: shared types, constants and the sine table builder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package oltw_pkg;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_STEP_COS    = 3'd0;
    localparam logic [2:0] REG_STEP_SIN    = 3'd1;
    localparam logic [2:0] REG_RING_RADIUS = 3'd2;
    localparam logic [2:0] REG_GLOW_PHASE  = 3'd3;
    localparam logic [2:0] REG_EDGE_GAIN   = 3'd4;
    localparam logic [2:0] REG_INK_FIRST   = 3'd5;
    localparam logic [2:0] REG_INK_SECOND  = 3'd6;
    localparam logic [2:0] REG_GROUND_INK  = 3'd7;

    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    localparam logic [23:0] ROOT_HALF_Q24 = 24'd11863283;
    localparam logic [24:0] CORE_W_Q24    = 25'd603980;
    localparam logic [24:0] EDGE_W_Q24    = 25'd1040187;
    localparam logic [23:0] ALONG_Q24     = 24'd14411629;
    localparam logic [22:0] STEP_Q24      = 23'd5066719;
    localparam logic [16:0] MOD_BASE_Q16  = 17'd40632;
    localparam logic [16:0] MOD_SWING_Q16 = 17'd24904;
    localparam logic [12:0] GROUND_DIM_Q16 = 13'd4588;
    localparam logic [16:0] WEIGHT_ONE    = 17'd65536;

    localparam logic [63:0] TAYLOR_DIV [12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    typedef struct packed {
        logic [9:0] pixel_column;
        logic [9:0] pixel_row;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_out_t;

    typedef struct packed {
        logic signed [25:0] step_cos;
        logic signed [25:0] step_sin;
        logic [15:0]        ring_radius;
        logic [9:0]         glow_phase;
        logic [15:0]        edge_gain;
        logic [23:0]        ink_first;
        logic [23:0]        ink_second;
        logic [23:0]        ground_ink;
    } cfg_t;

    // band distances and light phases for both lattices
    typedef struct packed {
        logic [19:0] core_a;
        logic [19:0] edge_a;
        logic [19:0] core_b;
        logic [19:0] edge_b;
        logic [23:0] phase_a;
        logic [23:0] phase_b;
        logic        top;
    } fold_t;

    // winning strap
    typedef struct packed {
        logic        ground;
        logic [16:0] core;
        logic [16:0] edge_w;
        logic [23:0] ink;
    } pick_t;

    // Q30 angle in, Q15 sine out, at elaboration only
    function automatic logic signed [16:0] sine_q15(input logic [63:0] phase);
        logic [63:0]        x;
        logic [63:0]        t;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        logic               neg;
        x = phase;
        neg = 1'b0;
        if (x >= Q30_PI)
        begin
            x = x - Q30_PI;
            neg = 1'b1;
        end
        if (x > Q30_HALF_PI)
        begin
            x = Q30_PI - x;
        end
        t = x;
        sum = $signed(x);
        for (int n = 0; n < 12; n++)
        begin
            t = (((t * x) >> 30) * x) >> 30;
            t = t / TAYLOR_DIV[n];
            if ((n % 2) == 0)
            begin
                sum = sum - $signed(t);
            end
            else
            begin
                sum = sum + $signed(t);
            end
        end
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        v = (sum + 64'sd16384) >>> 15;
        if (neg)
        begin
            v = -v;
        end
        return v[16:0];
    endfunction

endpackage

/* rtl/oltw_regs.sv */
// Configuration register file behind an APB-style port.
// Depends on oltw_pkg.
`timescale 1ns / 1ps
module oltw_regs
    import oltw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic write_en;

    assign write_en = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_cos    <= '0;
            cfg_reg.step_sin    <= '0;
            cfg_reg.ring_radius <= 16'd29622;
            cfg_reg.glow_phase  <= '0;
            cfg_reg.edge_gain   <= 16'd9216;
            cfg_reg.ink_first   <= 24'hFFFFFF;
            cfg_reg.ink_second  <= 24'hFFFFFF;
            cfg_reg.ground_ink  <= '0;
        end
        else if (write_en)
        begin
            unique case (paddr[4:2])
                REG_STEP_COS:    cfg_reg.step_cos    <= pwdata[25:0];
                REG_STEP_SIN:    cfg_reg.step_sin    <= pwdata[25:0];
                REG_RING_RADIUS: cfg_reg.ring_radius <= pwdata[15:0];
                REG_GLOW_PHASE:  cfg_reg.glow_phase  <= pwdata[9:0];
                REG_EDGE_GAIN:   cfg_reg.edge_gain   <= pwdata[15:0];
                REG_INK_FIRST:   cfg_reg.ink_first   <= pwdata[23:0];
                REG_INK_SECOND:  cfg_reg.ink_second  <= pwdata[23:0];
                REG_GROUND_INK:  cfg_reg.ground_ink  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_STEP_COS:    prdata = {6'd0, cfg_reg.step_cos};
            REG_STEP_SIN:    prdata = {6'd0, cfg_reg.step_sin};
            REG_RING_RADIUS: prdata = {16'd0, cfg_reg.ring_radius};
            REG_GLOW_PHASE:  prdata = {22'd0, cfg_reg.glow_phase};
            REG_EDGE_GAIN:   prdata = {16'd0, cfg_reg.edge_gain};
            REG_INK_FIRST:   prdata = {8'd0, cfg_reg.ink_first};
            REG_INK_SECOND:  prdata = {8'd0, cfg_reg.ink_second};
            REG_GROUND_INK:  prdata = {8'd0, cfg_reg.ground_ink};
            default:         prdata = '0;
        endcase
    end

endmodule

/* rtl/oltw_fold.sv */
// Front stages: centring, rotation, lattice fold, octagon metric, band distances, phases.
// Five register stages; depends on oltw_pkg.
`timescale 1ns / 1ps
module oltw_fold
    import oltw_pkg::*;
#(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 768
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  pixel_in_t pixel,
    input  cfg_t      cfg,
    output logic      out_valid,
    output fold_t     fold
);

    localparam int FMAX = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
    localparam int DW   = $clog2(FMAX + 2048) + 1;

    logic [4:0] valid_reg;

    // stage 1
    logic signed [DW-1:0] dx_reg, dy_reg;
    // stage 2
    logic signed [DW+25:0] xc_full, ys_full, xs_full, yc_full;
    logic [27:0] xc_reg, ys_reg, xs_reg, yc_reg;
    // stage 3
    logic [27:0] qx_full, qy_full;
    logic [26:0] tx, ty;
    logic [23:0] ax, ay, bx, by;
    logic [23:0] ua_next, va_next, ub_next, vb_next;
    logic [23:0] ua_reg, va_reg, ub_reg, vb_reg;
    logic signed [24:0] al_a_reg, al_b_reg;
    logic [2:0] sumc_reg, difc_reg;
    // stage 4
    logic [24:0] sum_a, sum_b;
    logic [48:0] sp_a, sp_b;
    logic signed [48:0] lp_a, lp_b;
    logic [23:0] m_a_reg, m_b_reg, l_a_reg, l_b_reg;
    logic [24:0] s_a_reg, s_b_reg;
    logic [2:0] sumc4_reg, difc4_reg;
    // stage 5
    logic [24:0] d_a, d_b, e_a, e_b;
    logic signed [25:0] r_a, r_b;
    logic [24:0] rad;
    logic [23:0] glow;
    fold_t fold_next, fold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= $signed({{(DW-11){1'b0}}, pixel.pixel_column, 1'b1})
                  - $signed(DW'(FRAME_WIDTH));
        dy_reg <= $signed({{(DW-11){1'b0}}, pixel.pixel_row, 1'b1})
                  - $signed(DW'(FRAME_HEIGHT));
    end

    assign xc_full = dx_reg * cfg.step_cos;
    assign ys_full = dy_reg * cfg.step_sin;
    assign xs_full = dx_reg * cfg.step_sin;
    assign yc_full = dy_reg * cfg.step_cos;

    always_ff @(posedge clk)
    begin
        xc_reg <= xc_full[27:0];
        ys_reg <= ys_full[27:0];
        xs_reg <= xs_full[27:0];
        yc_reg <= yc_full[27:0];
    end

    // low bits only: the fold needs the position modulo eight cells
    assign qx_full = xc_reg - ys_reg;
    assign qy_full = xs_reg + yc_reg;
    assign tx = qx_full[27:1] + 27'h0800000;
    assign ty = qy_full[27:1] + 27'h0800000;
    assign ax = qx_full[24:1];
    assign ay = qy_full[24:1];
    assign bx = {~ax[23], ax[22:0]};
    assign by = {~ay[23], ay[22:0]};
    assign ua_next = ax[23] ? (~ax + 24'd1) : ax;
    assign va_next = ay[23] ? (~ay + 24'd1) : ay;
    assign ub_next = bx[23] ? (~bx + 24'd1) : bx;
    assign vb_next = by[23] ? (~by + 24'd1) : by;

    always_ff @(posedge clk)
    begin
        ua_reg   <= ua_next;
        va_reg   <= va_next;
        ub_reg   <= ub_next;
        vb_reg   <= vb_next;
        al_a_reg <= $signed({ax[23], ax}) + $signed({ay[23], ay});
        al_b_reg <= $signed({bx[23], bx}) - $signed({by[23], by});
        sumc_reg <= tx[26:24] + ty[26:24];
        difc_reg <= tx[26:24] - ty[26:24];
    end

    assign sum_a = {1'b0, ua_reg} + {1'b0, va_reg};
    assign sum_b = {1'b0, ub_reg} + {1'b0, vb_reg};
    assign sp_a = {24'd0, sum_a} * {25'd0, ROOT_HALF_Q24};
    assign sp_b = {24'd0, sum_b} * {25'd0, ROOT_HALF_Q24};
    assign lp_a = al_a_reg * $signed({25'd0, ALONG_Q24});
    assign lp_b = al_b_reg * $signed({25'd0, ALONG_Q24});

    always_ff @(posedge clk)
    begin
        m_a_reg   <= (ua_reg > va_reg) ? ua_reg : va_reg;
        m_b_reg   <= (ub_reg > vb_reg) ? ub_reg : vb_reg;
        s_a_reg   <= sp_a[48:24];
        s_b_reg   <= sp_b[48:24];
        l_a_reg   <= lp_a[47:24];
        l_b_reg   <= lp_b[47:24];
        sumc4_reg <= sumc_reg;
        difc4_reg <= difc_reg;
    end

    assign rad  = {1'b0, cfg.ring_radius, 8'd0};
    assign glow = {cfg.glow_phase, 14'd0};
    assign d_a  = ({1'b0, m_a_reg} > s_a_reg) ? {1'b0, m_a_reg} : s_a_reg;
    assign d_b  = ({1'b0, m_b_reg} > s_b_reg) ? {1'b0, m_b_reg} : s_b_reg;
    assign r_a  = $signed({1'b0, d_a}) - $signed({1'b0, rad});
    assign r_b  = $signed({1'b0, d_b}) - $signed({1'b0, rad});
    assign e_a  = r_a[25] ? 25'(-r_a) : r_a[24:0];
    assign e_b  = r_b[25] ? 25'(-r_b) : r_b[24:0];

    always_comb
    begin
        fold_next.core_a = (e_a < CORE_W_Q24) ? 20'(CORE_W_Q24 - e_a) : 20'd0;
        fold_next.edge_a = (e_a < EDGE_W_Q24) ? 20'(EDGE_W_Q24 - e_a) : 20'd0;
        fold_next.core_b = (e_b < CORE_W_Q24) ? 20'(CORE_W_Q24 - e_b) : 20'd0;
        fold_next.edge_b = (e_b < EDGE_W_Q24) ? 20'(EDGE_W_Q24 - e_b) : 20'd0;
        fold_next.phase_a = l_a_reg + 24'({3'd0, sumc4_reg} * {3'd0, STEP_Q24}) - glow;
        fold_next.phase_b = l_b_reg + 24'({3'd0, difc4_reg} * {3'd0, STEP_Q24}) + glow;
        fold_next.top = sumc4_reg[0];
    end

    always_ff @(posedge clk)
    begin
        fold_reg <= fold_next;
    end

    assign fold = fold_reg;
    assign out_valid = valid_reg[4];

endmodule

/* rtl/oltw_glow.sv */
// Middle stages: band weights, sine table lookup, running light, strap choice.
// Four register stages; depends on oltw_pkg.
`timescale 1ns / 1ps
module oltw_glow
    import oltw_pkg::*;
#(
    parameter int SINE_ENTRIES = 1024
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  fold_t fold,
    input  cfg_t  cfg,
    output logic  out_valid,
    output pick_t pick
);

    localparam int IW = $clog2(SINE_ENTRIES);

    logic [3:0] valid_reg;

    logic signed [16:0] sine_rom [SINE_ENTRIES];

    for (genvar k = 0; k < SINE_ENTRIES; k++)
    begin : g_rom
        localparam logic [63:0] ANGLE = (Q30_TWO_PI * 64'(k)) / SINE_ENTRIES;
        localparam logic signed [16:0] VALUE = sine_q15(ANGLE);
        assign sine_rom[k] = VALUE;
    end

    // stage 6
    logic [35:0] wp_ca, wp_ga, wp_cb, wp_gb;
    logic [24+IW:0] ip_a, ip_b;
    logic [16:0] c_a_reg, g_a_reg, c_b_reg, g_b_reg;
    logic [IW-1:0] idx_a_reg, idx_b_reg;
    logic top_reg;
    // stage 7
    logic signed [16:0] rom_a_reg, rom_b_reg;
    logic [16:0] c_a7_reg, g_a7_reg, c_b7_reg, g_b7_reg;
    logic top7_reg;
    // stage 8
    logic signed [33:0] sw_a, sw_b, mf_a, mf_b;
    logic [16:0] m_a_reg, m_b_reg;
    logic [16:0] c_a8_reg, g_a8_reg, c_b8_reg, g_b8_reg;
    logic top8_reg;
    // stage 9
    logic [33:0] cp_a, cp_b;
    pick_t pick_next, pick_reg;

    function automatic logic [16:0] clamp_w(input logic [19:0] w);
        return (w > {3'd0, WEIGHT_ONE}) ? WEIGHT_ONE : w[16:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    assign wp_ca = {16'd0, fold.core_a} * {20'd0, cfg.edge_gain};
    assign wp_ga = {16'd0, fold.edge_a} * {20'd0, cfg.edge_gain};
    assign wp_cb = {16'd0, fold.core_b} * {20'd0, cfg.edge_gain};
    assign wp_gb = {16'd0, fold.edge_b} * {20'd0, cfg.edge_gain};
    assign ip_a = {{(IW+1){1'b0}}, fold.phase_a} * (25+IW)'(SINE_ENTRIES);
    assign ip_b = {{(IW+1){1'b0}}, fold.phase_b} * (25+IW)'(SINE_ENTRIES);

    always_ff @(posedge clk)
    begin
        c_a_reg   <= clamp_w(wp_ca[35:16]);
        g_a_reg   <= clamp_w(wp_ga[35:16]);
        c_b_reg   <= clamp_w(wp_cb[35:16]);
        g_b_reg   <= clamp_w(wp_gb[35:16]);
        idx_a_reg <= ip_a[23+IW:24];
        idx_b_reg <= ip_b[23+IW:24];
        top_reg   <= fold.top;
    end

    always_ff @(posedge clk)
    begin
        rom_a_reg <= sine_rom[idx_a_reg];
        rom_b_reg <= sine_rom[idx_b_reg];
        c_a7_reg  <= c_a_reg;
        g_a7_reg  <= g_a_reg;
        c_b7_reg  <= c_b_reg;
        g_b7_reg  <= g_b_reg;
        top7_reg  <= top_reg;
    end

    assign sw_a = rom_a_reg * $signed({17'd0, MOD_SWING_Q16});
    assign sw_b = rom_b_reg * $signed({17'd0, MOD_SWING_Q16});
    assign mf_a = $signed({17'd0, MOD_BASE_Q16}) + (sw_a >>> 15);
    assign mf_b = $signed({17'd0, MOD_BASE_Q16}) + (sw_b >>> 15);

    always_ff @(posedge clk)
    begin
        m_a_reg  <= mf_a[16:0];
        m_b_reg  <= mf_b[16:0];
        c_a8_reg <= c_a7_reg;
        g_a8_reg <= g_a7_reg;
        c_b8_reg <= c_b7_reg;
        g_b8_reg <= g_b7_reg;
        top8_reg <= top7_reg;
    end

    assign cp_a = {17'd0, c_a8_reg} * {17'd0, m_a_reg};
    assign cp_b = {17'd0, c_b8_reg} * {17'd0, m_b_reg};

    // odd parity puts the offset lattice on top
    always_comb
    begin
        pick_next.ground = 1'b0;
        pick_next.core   = cp_a[32:16];
        pick_next.edge_w = g_a8_reg;
        pick_next.ink    = cfg.ink_first;
        if (top8_reg && (g_b8_reg != '0))
        begin
            pick_next.core   = cp_b[32:16];
            pick_next.edge_w = g_b8_reg;
            pick_next.ink    = cfg.ink_second;
        end
        else if (g_a8_reg != '0)
        begin
            pick_next.core   = cp_a[32:16];
            pick_next.edge_w = g_a8_reg;
            pick_next.ink    = cfg.ink_first;
        end
        else if (g_b8_reg != '0)
        begin
            pick_next.core   = cp_b[32:16];
            pick_next.edge_w = g_b8_reg;
            pick_next.ink    = cfg.ink_second;
        end
        else
        begin
            pick_next.ground = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
    end

    assign pick = pick_reg;
    assign out_valid = valid_reg[3];

endmodule

/* rtl/oltw_mix.sv */
// Back stages: ink scaling by core and edge weights, ground dimming, saturation.
// Two register stages; depends on oltw_pkg.
`timescale 1ns / 1ps
module oltw_mix
    import oltw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  pick_t      pick,
    input  cfg_t       cfg,
    output logic       done,
    output pixel_out_t color
);

    logic [1:0] valid_reg;

    logic [24:0] cc_prod [3];
    logic [20:0] gr_prod [3];
    logic [8:0]  cc_reg [3];
    logic [4:0]  gr_reg [3];
    logic [16:0] edge_reg;
    logic        ground_reg;

    logic [25:0] ch_prod [3];
    logic [7:0]  ch_next [3];
    pixel_out_t  color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_chan
        assign cc_prod[j] = {17'd0, pick.ink[23-8*j -: 8]} * {8'd0, pick.core};
        assign gr_prod[j] = {13'd0, cfg.ground_ink[23-8*j -: 8]}
                            * {8'd0, GROUND_DIM_Q16};
        assign ch_prod[j] = {17'd0, cc_reg[j]} * {9'd0, edge_reg};

        always_ff @(posedge clk)
        begin
            cc_reg[j] <= cc_prod[j][24:16];
            gr_reg[j] <= gr_prod[j][20:16];
        end

        always_comb
        begin
            if (ground_reg)
            begin
                ch_next[j] = {3'd0, gr_reg[j]};
            end
            else if (ch_prod[j][25:16] > 10'd255)
            begin
                ch_next[j] = 8'd255;
            end
            else
            begin
                ch_next[j] = ch_prod[j][23:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        edge_reg   <= pick.edge_w;
        ground_reg <= pick.ground;
        color_reg  <= '{red: ch_next[0], green: ch_next[1], blue: ch_next[2]};
    end

    assign color = color_reg;
    assign done = valid_reg[1];

endmodule

/* rtl/octagon_lattice_weave_shader_core.sv */
// Octagon lattice weave shader, top level: register port and the three pipeline sections.
// Depends on oltw_pkg, oltw_regs, oltw_fold, oltw_glow, oltw_mix.
`timescale 1ns / 1ps
// One pixel in per clock, one RGB colour out per pixel, in order. busy is always
// low, so a start is taken every cycle it is high. The colour appears on color
// with done high for one cycle, after the register stages of the three sections:
// five of rotation and fold, four of weight, sine table and light, two of ink blend.
// The receiver cannot stall; results must be captured when done is high.
// Write configuration only while no pixel is in flight.
module octagon_lattice_weave_shader_core
    import oltw_pkg::*;
#(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 768,
    parameter int SINE_ENTRIES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pixel_in_t         pixel,
    output logic              done,
    output pixel_out_t        color,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t  cfg;
    fold_t fold;
    pick_t pick;
    logic  fold_valid;
    logic  pick_valid;

    assign busy = 1'b0;

    oltw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    oltw_fold #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .pixel     (pixel),
        .cfg       (cfg),
        .out_valid (fold_valid),
        .fold      (fold)
    );

    oltw_glow #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_glow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fold_valid),
        .fold      (fold),
        .cfg       (cfg),
        .out_valid (pick_valid),
        .pick      (pick)
    );

    oltw_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pick_valid),
        .pick     (pick),
        .cfg      (cfg),
        .done     (done),
        .color    (color)
    );

endmodule
